/* design/bvde_pkg.sv */
//------------------------------------------------------------------------------
// bvde_pkg
// Shared types, constants and the per-lane term function of the byte vector
// distance engine.
//------------------------------------------------------------------------------
`default_nettype none

package bvde_pkg;

	// Number of byte lanes worked on per chunk.
	localparam int unsigned LANES = 8;
	// Bytes physically present in one 64-bit input word.
	localparam int unsigned WORD_LANES = 8;
	localparam int unsigned WORD_W = 8 * WORD_LANES;
	localparam int unsigned TERM_W = 16;
	localparam int unsigned CHUNK_W = TERM_W + $clog2(LANES);
	localparam int unsigned DIST_W = 32;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_ABS  = 2'd0,
		KIND_SQR  = 2'd1,
		KIND_BOX  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic [TERM_W-1:0] term_t;

	// One classified chunk on its way from the front end to the accumulator.
	typedef struct packed {
		logic [CHUNK_W-1:0] sum;
		logic               last;
	} chunk_item_t;

	function automatic term_t lane_term(input kind_t kind, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] hi);
		logic [7:0] d;
		logic [8:0] lo_part;
		logic [8:0] hi_part;
		term_t      res;
		d = (a > b) ? (a - b) : (b - a);
		lo_part = (a < b) ? {1'b0, b - a} : 9'd0;
		hi_part = (a > hi) ? {1'b0, a - hi} : 9'd0;
		unique case (kind)
			KIND_ABS:  res = {8'd0, d};
			KIND_SQR:  res = d * d;
			KIND_BOX:  res = {7'd0, lo_part + hi_part};
			KIND_NONE: res = '0;
			default:   res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

/* design/bvde_in_if.sv */
//------------------------------------------------------------------------------
// bvde_in_if
// Chunk request channel: kind, three byte vectors and the last marker.
//------------------------------------------------------------------------------
`default_nettype none

interface bvde_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] vec_a_bytes;
	logic [63:0] vec_b_bytes;
	logic [63:0] box_upper_bytes;
	logic        last_chunk;

	modport source (output valid, kind, vec_a_bytes, vec_b_bytes, box_upper_bytes,
		last_chunk, input ready);
	modport sink (input valid, kind, vec_a_bytes, vec_b_bytes, box_upper_bytes,
		last_chunk, output ready);
endinterface

`default_nettype wire

/* design/bvde_out_if.sv */
//------------------------------------------------------------------------------
// bvde_out_if
// Result request channel carrying one 32-bit distance.
//------------------------------------------------------------------------------
`default_nettype none

interface bvde_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface

`default_nettype wire

/* design/bvde_front.sv */
//------------------------------------------------------------------------------
// bvde_front
// Accepts chunk requests, registers the per-lane terms and sums them into
// one chunk item for the queue.
//------------------------------------------------------------------------------
`default_nettype none

module bvde_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	bvde_in_if.sink             chunk,
	output bvde_pkg::chunk_item_t item,
	output logic                item_valid,
	input  wire logic           item_ready
);
	import bvde_pkg::*;

	term_t              terms_comb [LANES];
	term_t              terms_s1   [LANES];
	logic               last_s1;
	logic               valid_s1;
	logic               accept;
	logic [CHUNK_W-1:0] sum;

	assign chunk.ready = !valid_s1 || item_ready;
	assign accept      = chunk.valid && chunk.ready;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		if (l < WORD_LANES) begin : g_real
			assign terms_comb[l] = lane_term(kind_t'(chunk.kind),
				chunk.vec_a_bytes[8*l +: 8], chunk.vec_b_bytes[8*l +: 8],
				chunk.box_upper_bytes[8*l +: 8]);
		end else begin : g_pad
			// Lanes past the input word get a zero term and add nothing.
			assign terms_comb[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chunk.ready) begin
			valid_s1 <= chunk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			terms_s1 <= terms_comb;
			last_s1  <= chunk.last_chunk;
		end
	end

	always_comb begin
		sum = '0;
		for (int l = 0; l < LANES; l++) begin
			sum = sum + CHUNK_W'(terms_s1[l]);
		end
	end

	assign item.sum   = sum;
	assign item.last  = last_s1;
	assign item_valid = valid_s1;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted chunk did not reach the term register");

endmodule

`default_nettype wire

/* design/bvde_queue.sv */
//------------------------------------------------------------------------------
// bvde_queue
// Short FIFO between the front end and the accumulator.
//------------------------------------------------------------------------------
`default_nettype none

module bvde_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  bvde_pkg::chunk_item_t push_item,
	input  wire logic             push_valid,
	output logic                  push_ready,
	output bvde_pkg::chunk_item_t pop_item,
	output logic                  pop_valid,
	input  wire logic             pop_ready
);
	import bvde_pkg::*;

	chunk_item_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a push");

endmodule

`default_nettype wire

/* design/bvde_back.sv */
//------------------------------------------------------------------------------
// bvde_back
// Running-sum accumulator and registered result output.
//------------------------------------------------------------------------------
`default_nettype none

module bvde_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  bvde_pkg::chunk_item_t item,
	input  wire logic             item_valid,
	output logic                  item_ready,
	bvde_out_if.source            result
);
	import bvde_pkg::*;

	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] distance_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] new_sum;
	logic              pop;

	assign item_ready = !out_valid_q || result.ready;
	assign pop        = item_valid && item_ready;
	assign new_sum    = acc_q + DIST_W'(item.sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (item.last) begin
					acc_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					acc_q <= new_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			distance_q <= new_sum;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = distance_q;

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.last |=> acc_q == '0 && out_valid_q)
		else $error("last chunk did not emit and clear the sum");

endmodule

`default_nettype wire

/* design/byte_vector_distance_engine.sv */
//------------------------------------------------------------------------------
// byte_vector_distance_engine
// Sums absolute, squared or box distances over streams of byte-vector chunks.
//------------------------------------------------------------------------------
//
//  Channel   Role    Contents per request
//  --------  ------  ---------------------------------------------------------
//  chunk     sink    kind, vec_a_bytes, vec_b_bytes, box_upper_bytes,
//                    last_chunk
//  result    source  distance (32-bit running sum, modulo 2^32)
//
//  One chunk request is taken every clock cycle when nothing stalls.
//  A chunk's terms are held in the term register (eight 8x8 multipliers
//  feed it), are summed into the queue from that register and are folded into
//  the accumulator when the chunk leaves the queue; the distance is registered
//  as its last chunk is folded in.
//  The four-entry queue lets the front end keep taking requests while the
//  result register waits to be taken. Reset clears all control state and
//  the running sum; no clearing pass is needed.
//
`default_nettype none

module byte_vector_distance_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	bvde_in_if.sink   chunk,
	bvde_out_if.source result
);
	import bvde_pkg::*;

	// Front end to queue.
	chunk_item_t front_item;
	logic        front_valid;
	logic        front_ready;

	// Queue to accumulator.
	chunk_item_t back_item;
	logic        back_valid;
	logic        back_ready;

	// The front end works out every lane's term and the chunk's sum, so the
	// back end has only a single 32-bit add to do per chunk.
	bvde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chunk      (chunk),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	bvde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (back_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// The back end only stalls the queue while a finished distance has not
	// yet been taken and nothing frees the output register.
	bvde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.result     (result)
	);

endmodule

`default_nettype wire
